### design/rmf_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the running median filter.
package rmf_pkg;

    localparam int WINDOW_MAX   = 16;
    localparam int SAMPLE_WIDTH = 16;

    // Width of the window length register.
    localparam int CFG_W = 5;
    localparam int CFG_RESET = 5;

    // Slot index / age tag width and window length width.
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    // Stream data width, rounded up to whole bytes.
    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    // Function codes carried in the input tuser.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic             clear;
        logic             add;
        logic             up;
        logic             down;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] ptr;
        logic [LEN_W-1:0] len;
        sample_t          x;
    } rmf_ctrl_t;

endpackage

### design/rmf_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted window: a value and its age tag.
module rmf_cell
    import rmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  rmf_ctrl_t        ctrl,
    input  sample_t          left_val,
    input  logic [IDX_W-1:0] left_tag,
    input  sample_t          right_val,
    input  logic [IDX_W-1:0] right_tag,
    output sample_t          val,
    output logic [IDX_W-1:0] tag
);

    sample_t          val_reg;
    sample_t          val_next;
    logic [IDX_W-1:0] tag_reg;
    logic [IDX_W-1:0] tag_next;
    logic [LEN_W-1:0] idx_ext;
    logic [LEN_W-1:0] nxt_ext;
    logic             in_win;

    always_comb
    begin
        idx_ext  = LEN_W'(idx);
        nxt_ext  = idx_ext + LEN_W'(1);
        in_win   = (idx_ext < ctrl.len);
        val_next = val_reg;
        tag_next = tag_reg;
        if (ctrl.clear)
        begin
            val_next = '0;
            tag_next = idx;
        end
        else if (ctrl.add && in_win)
        begin
            if (ctrl.up)
            begin
                // The hole moves up; values below the new sample slide down.
                if (idx >= ctrl.pos && nxt_ext < ctrl.len && right_val < ctrl.x)
                begin
                    val_next = right_val;
                    tag_next = right_tag;
                end
                else if (idx > ctrl.pos && val_reg < ctrl.x)
                begin
                    val_next = ctrl.x;
                    tag_next = ctrl.ptr;
                end
            end
            else if (ctrl.down)
            begin
                if (idx <= ctrl.pos && idx != '0 && left_val > ctrl.x)
                begin
                    val_next = left_val;
                    tag_next = left_tag;
                end
                else if (idx < ctrl.pos && val_reg > ctrl.x)
                begin
                    val_next = ctrl.x;
                    tag_next = ctrl.ptr;
                end
            end
            else if (idx == ctrl.pos)
            begin
                val_next = ctrl.x;
                tag_next = ctrl.ptr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            tag_reg <= idx;
        end
        else
        begin
            val_reg <= val_next;
            tag_reg <= tag_next;
        end
    end

    assign val = val_reg;
    assign tag = tag_reg;

endmodule

### design/running_median_filter.sv
`timescale 1ns / 1ps
// Top level of the running median filter: cell row, control and stream ports.
// A request updates the cell row at the edge where it is accepted; its median is
// then held pending and loaded into the output register once that register is free.
// Throughput: one request per cycle unless a pending median waits on a stalled output;
// cells update together from their neighbours, and the output register decouples stalls.
// Reset clears the window to zeros, tags slot i with i, the pointer to zero and
// the window length to five; there is no clearing pass.
module running_median_filter
    import rmf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Window length register write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    // Input stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // sample
    input  logic              s_tuser,   // func
    // Output stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata    // median_value
);

    logic [CFG_W-1:0] wlen_reg;
    logic [CFG_W-1:0] wlen_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic             pend_reg;
    logic             pend_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    sample_t          median_reg;
    sample_t          median_next;

    sample_t          val [WINDOW_MAX];
    logic [IDX_W-1:0] tag [WINDOW_MAX];

    logic             cfg_wr;
    logic             s_acc;
    logic             out_free;
    logic [LEN_W-1:0] eff_len;
    logic [IDX_W-1:0] pos;
    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] ptr_inc;
    sample_t          x;
    sample_t          above_val;
    sample_t          below_val;
    rmf_ctrl_t        ctrl;

    // Config register is always writable; the user must write it only while idle.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // A new request may enter unless a median is still waiting to be sampled from
    // the cell row and the output register cannot take it in this cycle.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !pend_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;

    assign x = s_tdata[SAMPLE_WIDTH-1:0];

    // Effective window length saturates at the depth of the row.
    always_comb
    begin
        if (32'(wlen_reg) > WINDOW_MAX)
        begin
            eff_len = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = LEN_W'(wlen_reg);
        end
    end

    // The oldest slot is the first in the window whose tag matches the pointer;
    // when none matches, the top slot of the window is replaced.
    always_comb
    begin
        pos = IDX_W'(eff_len - LEN_W'(1));
        for (int i = WINDOW_MAX - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < eff_len && tag[i] == ptr_reg)
            begin
                pos = IDX_W'(i);
            end
        end
    end

    // Neighbours of the removed slot decide which way the new sample travels.
    assign pos_ext   = LEN_W'(pos);
    assign above_val = val[IDX_W'(pos_ext + LEN_W'(1))];
    assign below_val = val[IDX_W'(pos_ext - LEN_W'(1))];

    always_comb
    begin
        ctrl.clear = cfg_wr || (s_acc && s_tuser == FUNC_CLEAR);
        ctrl.add   = s_acc && s_tuser == FUNC_ADD && eff_len != '0;
        ctrl.up    = (pos_ext + LEN_W'(1) < eff_len) && (above_val < x);
        ctrl.down  = !ctrl.up && (pos != '0) && (below_val > x);
        ctrl.pos   = pos;
        ctrl.ptr   = ptr_reg;
        ctrl.len   = eff_len;
        ctrl.x     = x;
    end

    // The row of cells; each slot sees the slot below and the slot above it.
    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        sample_t          lv;
        logic [IDX_W-1:0] lt;
        sample_t          rv;
        logic [IDX_W-1:0] rt;

        if (g > 0)
        begin : g_left
            assign lv = val[g-1];
            assign lt = tag[g-1];
        end
        else
        begin : g_left_edge
            assign lv = '0;
            assign lt = '0;
        end

        if (g < WINDOW_MAX - 1)
        begin : g_right
            assign rv = val[g+1];
            assign rt = tag[g+1];
        end
        else
        begin : g_right_edge
            assign rv = '0;
            assign rt = '0;
        end

        rmf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (IDX_W'(g)),
            .ctrl      (ctrl),
            .left_val  (lv),
            .left_tag  (lt),
            .right_val (rv),
            .right_tag (rt),
            .val       (val[g]),
            .tag       (tag[g])
        );
    end

    // Pointer, configuration and output register updates.
    always_comb
    begin
        ptr_inc       = LEN_W'(ptr_reg) + LEN_W'(1);
        wlen_next     = wlen_reg;
        ptr_next      = ptr_reg;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg;
        median_next   = median_reg;

        if (cfg_wr)
        begin
            wlen_next = cfg_data;
        end

        if (ctrl.clear)
        begin
            ptr_next = '0;
        end
        else if (ctrl.add)
        begin
            if (ptr_inc >= eff_len)
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = IDX_W'(ptr_inc);
            end
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // The median is sampled from the updated row once the output register is free.
        if (pend_reg && out_free)
        begin
            median_next   = val[IDX_W'(eff_len >> 1)];
            m_tvalid_next = 1'b1;
            pend_next     = 1'b0;
        end

        if (s_acc)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg     <= CFG_W'(CFG_RESET);
            ptr_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            wlen_reg     <= wlen_next;
            ptr_reg      <= ptr_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'({{(DATA_W - SAMPLE_WIDTH){1'b0}}, median_reg});

    // A clear request leaves the pointer at the first slot.
    a_clear_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tuser == FUNC_CLEAR |=> ptr_reg == '0)
        else $error("pointer not reset by clear request");

    // The pointer addresses a slot inside the window whenever it is not empty.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        eff_len != '0 |-> LEN_W'(ptr_reg) < eff_len)
        else $error("pointer outside the window");

    // The two lowest slots stay in ascending order.
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        eff_len > LEN_W'(1) |-> val[0] <= val[IDX_W'(1)])
        else $error("window lost its ordering");

    // A pending median reaches the output register as soon as it is free.
    a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && out_free |=> m_tvalid_reg)
        else $error("pending median not delivered");

endmodule
